// File: design/hnbt_pkg.sv
`timescale 1ns / 1ps

package hnbt_pkg;

	// Default depth of the frame byte queue (holds one entry less than this).
	localparam int QUEUE_DEPTH_DEF = 256;

	// Line constants.
	localparam logic [7:0] FLAG_BYTE   = 8'h7E;
	localparam logic [2:0] STUFF_LIMIT = 3'd5;
	localparam logic [2:0] ONES_MAX    = 3'd7;

	// Register reset values.
	localparam logic [7:0] ESCAPE_RESET = 8'd27;
	localparam logic [7:0] RESETC_RESET = 8'd127;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_PREAMBLE = 2'd0,
		CFG_TAIL     = 2'd1,
		CFG_ESCAPE   = 2'd2,
		CFG_RESETC   = 2'd3
	} cfg_idx_t;

	// Head of the queue as seen by the serializer.
	typedef struct packed {
		logic       empty;
		logic       single;
		logic [1:0] head_cnt;
		logic [7:0] head0;
		logic [7:0] head1;
	} q_status_t;

	// Result of one processed item.
	typedef struct packed {
		logic bit_sent;
		logic tone_space;
		logic keyed;
	} ser_res_t;

endpackage

// File: design/hnbt_queue.sv
`timescale 1ns / 1ps

// Frame byte queue: a memory with registered read data behind two head
// registers that hold up to the first two queued bytes.
module hnbt_queue #(
	parameter int QUEUE_DEPTH = hnbt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [7:0]            push_data,
	input  logic [1:0]            pop_cnt,
	output logic                  push_ok,
	output hnbt_pkg::q_status_t   status
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [7:0]    mem [QUEUE_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW-1:0] cnt_q, cnt_d;
	logic [1:0]    hcnt_q, n;
	logic [7:0]    hd0_q, hd1_q, h0, h1;
	logic          rd_pend_q;
	logic [7:0]    rdata_q;
	logic          full, mem_empty, direct, mem_we, rd_issue;

	assign full      = (cnt_q == AW'(QUEUE_DEPTH - 1));
	assign push_ok   = push && !full;
	assign mem_empty = (wp_q == rp_q);

	// Head update: drop popped bytes, then append returning read data or a
	// push that can bypass the memory.
	always_comb begin
		n  = hcnt_q;
		h0 = hd0_q;
		h1 = hd1_q;
		case (pop_cnt)
			2'd1: begin
				h0 = hd1_q;
				n  = hcnt_q - 2'd1;
			end
			2'd2: begin
				n = hcnt_q - 2'd2;
			end
			default: begin
			end
		endcase
		if (rd_pend_q) begin
			if (n == 2'd0) begin
				h0 = rdata_q;
			end else begin
				h1 = rdata_q;
			end
			n = n + 2'd1;
		end
		direct = push_ok && mem_empty && !rd_pend_q && (n < 2'd2);
		if (direct) begin
			if (n == 2'd0) begin
				h0 = push_data;
			end else begin
				h1 = push_data;
			end
			n = n + 2'd1;
		end
		mem_we   = push_ok && !direct;
		rd_issue = !mem_empty && (n < 2'd2);
		cnt_d    = cnt_q + AW'(push_ok) - AW'(pop_cnt);
	end

	// Pointers, counts and head state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			cnt_q     <= '0;
			hcnt_q    <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (mem_we) begin
				wp_q <= (wp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_issue) begin
				rp_q <= (rp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q     <= cnt_d;
			hcnt_q    <= n;
			rd_pend_q <= rd_issue;
		end
	end

	// Head payload registers.
	always_ff @(posedge clk) begin
		hd0_q <= h0;
		hd1_q <= h1;
	end

	// Queue memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= push_data;
		end
		if (rd_issue) begin
			rdata_q <= mem[rp_q];
		end
	end

	assign status.empty    = (cnt_q == '0);
	assign status.single   = (cnt_q == AW'(1));
	assign status.head_cnt = hcnt_q;
	assign status.head0    = hd0_q;
	assign status.head1    = hd1_q;

endmodule

// File: design/hnbt_serializer.sv
`timescale 1ns / 1ps

// Bit serializer: flag and byte sequencing, zero stuffing and NRZI tone.
module hnbt_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                kind,
	input  logic [15:0]         preamble_flags,
	input  logic [15:0]         tail_flags,
	input  logic [7:0]          escape_code,
	input  logic [7:0]          reset_code,
	input  hnbt_pkg::q_status_t qs,
	output logic [1:0]          pop_cnt,
	output hnbt_pkg::ser_res_t  res
);

	logic [15:0] pre_q, pre_d, tail_q, tail_d;
	logic [2:0]  ones_q, ones_d;
	logic        stuff_q, stuff_d;
	logic [7:0]  sb_q, sb_d, mask_q, mask_d;
	logic        act_q, act_d, tone_q, tone_d;
	logic        emit, popped, empty_after;

	// Next state for one push or one bit tick.
	always_comb begin
		pre_d       = pre_q;
		tail_d      = tail_q;
		ones_d      = ones_q;
		stuff_d     = stuff_q;
		sb_d        = sb_q;
		mask_d      = mask_q;
		act_d       = act_q;
		tone_d      = tone_q;
		emit        = 1'b0;
		popped      = 1'b0;
		empty_after = 1'b0;
		pop_cnt     = 2'd0;
		if (step) begin
			if (!kind) begin
				// A push keys an idle transmitter on the mark tone.
				if (!act_q) begin
					act_d  = 1'b1;
					pre_d  = preamble_flags;
					tail_d = tail_flags;
					tone_d = 1'b0;
				end
			end else if (act_q) begin
				emit = 1'b1;
				if (mask_q == '0) begin
					if (qs.empty && (tail_q == '0)) begin
						act_d = 1'b0;
						emit  = 1'b0;
					end else begin
						if (!stuff_q) begin
							ones_d = '0;
						end
						stuff_d = 1'b1;
						if (pre_q == '0) begin
							if (qs.empty) begin
								tail_d = tail_q - 16'd1;
								sb_d   = hnbt_pkg::FLAG_BYTE;
							end else begin
								tail_d = tail_flags;
								sb_d   = qs.head0;
								popped = 1'b1;
							end
						end else begin
							pre_d = pre_q - 16'd1;
							sb_d  = hnbt_pkg::FLAG_BYTE;
						end
						pop_cnt     = {1'b0, popped};
						empty_after = popped ? qs.single : qs.empty;
						mask_d      = 8'd1;
						if (sb_d == escape_code) begin
							if (empty_after) begin
								// Escape with nothing behind it stops the frame.
								act_d  = 1'b0;
								mask_d = '0;
								emit   = 1'b0;
							end else begin
								sb_d    = popped ? qs.head1 : qs.head0;
								pop_cnt = pop_cnt + 2'd1;
							end
						end else if ((sb_d == hnbt_pkg::FLAG_BYTE) || (sb_d == reset_code)) begin
							stuff_d = 1'b0;
						end
					end
				end
				if (emit) begin
					if (stuff_d && (ones_d >= hnbt_pkg::STUFF_LIMIT)) begin
						// Stuffed zero: toggles the tone, consumes no data bit.
						tone_d = ~tone_d;
						ones_d = '0;
					end else begin
						if ((sb_d & mask_d) != '0) begin
							if (ones_d != hnbt_pkg::ONES_MAX) begin
								ones_d = ones_d + 3'd1;
							end
						end else begin
							tone_d = ~tone_d;
							ones_d = '0;
						end
						mask_d = {mask_d[6:0], 1'b0};
					end
				end
			end
		end
		res.bit_sent   = emit;
		res.tone_space = tone_d;
		res.keyed      = act_d;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q   <= '0;
			tail_q  <= '0;
			ones_q  <= '0;
			stuff_q <= 1'b0;
			sb_q    <= '0;
			mask_q  <= '0;
			act_q   <= 1'b0;
			tone_q  <= 1'b0;
		end else begin
			pre_q   <= pre_d;
			tail_q  <= tail_d;
			ones_q  <= ones_d;
			stuff_q <= stuff_d;
			sb_q    <= sb_d;
			mask_q  <= mask_d;
			act_q   <= act_d;
			tone_q  <= tone_d;
		end
	end

endmodule

// File: design/hdlc_nrzi_bit_stuffing_transmitter.sv
`timescale 1ns / 1ps

// HDLC transmitter with zero stuffing and NRZI tone keying.
// Input channel (in_valid/in_stall): kind 0 pushes data_byte into the frame
// queue, kind 1 is one bit-period tick. Every transfer gives exactly one
// result on the output channel (out_valid/out_stall): push_accepted,
// bit_sent, the tone after the item (0 mark, 1 space) and the keyed state.
// A push keys an idle transmitter; ticks then send preamble flags, queued
// bytes LSB first and tail flags until the queue drains.
// An item is captured in the input register and its result is registered in
// the output register. One item is taken every cycle while the receiver does
// not stall; the serializer state and queue head update in that single
// step, and the queue memory refills the head registers in the background.
// When the receiver stalls with a result waiting, the input register holds
// its item and in_stall rises in the same cycle; nothing is lost.
// Reset clears the queue, unkeys the transmitter (mark tone) and loads the
// register defaults; the queue memory needs no clearing pass.
// Configuration writes (cfg_valid/cfg_ready) are always taken and should be
// made only while the block is idle.
module hdlc_nrzi_bit_stuffing_transmitter #(
	parameter int QUEUE_DEPTH = hnbt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        push_accepted,
	output logic        bit_sent,
	output logic        tone_space,
	output logic        keyed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic                valid_s1, kind_s1;
	logic [7:0]          data_s1;
	logic                out_valid_q, push_acc_q, bit_sent_q, tone_q, keyed_q;
	logic [15:0]         pre_flags_q, tail_flags_q;
	logic [7:0]          esc_code_q, rst_code_q;
	logic                adv, step, push_ok;
	logic [1:0]          pop_cnt;
	hnbt_pkg::q_status_t qs;
	hnbt_pkg::ser_res_t  res;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign step      = valid_s1 && adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_flags_q  <= '0;
			tail_flags_q <= '0;
			esc_code_q   <= hnbt_pkg::ESCAPE_RESET;
			rst_code_q   <= hnbt_pkg::RESETC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (hnbt_pkg::cfg_idx_t'(cfg_index))
				hnbt_pkg::CFG_PREAMBLE: pre_flags_q  <= cfg_data;
				hnbt_pkg::CFG_TAIL:     tail_flags_q <= cfg_data;
				hnbt_pkg::CFG_ESCAPE:   esc_code_q   <= cfg_data[7:0];
				hnbt_pkg::CFG_RESETC:   rst_code_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			data_s1 <= data_byte;
		end
	end

	hnbt_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step && !kind_s1),
		.push_data (data_s1),
		.pop_cnt   (pop_cnt),
		.push_ok   (push_ok),
		.status    (qs)
	);

	hnbt_serializer u_ser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.kind           (kind_s1),
		.preamble_flags (pre_flags_q),
		.tail_flags     (tail_flags_q),
		.escape_code    (esc_code_q),
		.reset_code     (rst_code_q),
		.qs             (qs),
		.pop_cnt        (pop_cnt),
		.res            (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			push_acc_q <= push_ok;
			bit_sent_q <= res.bit_sent;
			tone_q     <= res.tone_space;
			keyed_q    <= res.keyed;
		end
	end

	assign out_valid     = out_valid_q;
	assign push_accepted = push_acc_q;
	assign bit_sent      = bit_sent_q;
	assign tone_space    = tone_q;
	assign keyed         = keyed_q;

`ifndef SYNTHESIS
	// The serializer never takes more bytes than the head registers hold.
	a_pop_within_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop_cnt <= qs.head_cnt)
		else $error("pop beyond queue head");

	// A result reports either an accepted push or a sent bit, never both.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(push_acc_q && bit_sent_q))
		else $error("push and bit in one result");

	// An unkeyed transmitter always leaves the queue empty.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !keyed_q) |-> qs.empty)
		else $error("idle with queued bytes");

	// A sent bit only happens while keyed.
	a_bit_keyed: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.bit_sent |=> keyed_q)
		else $error("bit sent while unkeyed");
`endif

endmodule
